// ===== hw/rtl/pdmf_pkg.sv =====
// Shared types, constants and helper functions for the pattern dither mask fill block.
// Used by every module under hw/rtl; it depends on nothing else.
package pdmf_pkg;

  // Field and register widths fixed by the register map and stream format
  localparam int MODE_W      = 5;
  localparam int PERIOD_W    = 8;
  localparam int COLOR_W     = 8;
  localparam int OFFSET_W    = 12;
  localparam int MASK_W      = 8;
  localparam int CODE_W      = 4;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_TDATA_W = ((1 + COLOR_W + 7) / 8) * 8;

  // Restoring division steps done in one pipeline stage
  localparam int DIV_BITS_PER_STAGE = 4;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_DITHER_MODE = 3'd0,
    REG_PERIOD      = 3'd1,
    REG_FILL_COLOR  = 3'd2,
    REG_X_OFFSET    = 3'd3,
    REG_Y_OFFSET    = 3'd4
  } reg_idx_t;

  // Pattern codes held in dither_mode[4:1]; codes eight and up paint everything
  typedef enum logic [CODE_W-1:0] {
    PAT_CHECKER    = 4'd0,
    PAT_CRISSCROSS = 4'd1,
    PAT_DIAG_DR    = 4'd2,
    PAT_DIAG_UR    = 4'd3,
    PAT_ROWS       = 4'd4,
    PAT_COLUMNS    = 4'd5,
    PAT_DOTS       = 4'd6,
    PAT_GRID       = 4'd7
  } pattern_t;

  // Configuration register contents
  typedef struct packed {
    logic [MODE_W-1:0]   dither_mode;
    logic [PERIOD_W-1:0] period;
    logic [COLOR_W-1:0]  fill_color;
    logic [OFFSET_W-1:0] x_offset;
    logic [OFFSET_W-1:0] y_offset;
  } cfg_t;

  // Per-request division state carried down the pipeline
  typedef struct packed {
    logic [PERIOD_W-1:0] rem_x;
    logic [PERIOD_W-1:0] rem_y;
    logic                qbit_x;
    logic                qbit_y;
    logic                mask_nz;
  } div_state_t;

  // One restoring division step result
  typedef struct packed {
    logic [PERIOD_W-1:0] rem;
    logic                q;
  } div_step_t;

  // Shift one dividend bit into the partial remainder and try to subtract.
  // rem < divisor, so the trial value fits PERIOD_W+1 bits and the new
  // remainder fits PERIOD_W bits.
  function automatic div_step_t div_step(input logic [PERIOD_W-1:0] rem,
                                         input logic                bit_in,
                                         input logic [PERIOD_W-1:0] divisor);
    logic [PERIOD_W:0] trial;
    logic [PERIOD_W:0] diff;
    div_step_t         res;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      res.rem = diff[PERIOD_W-1:0];
      res.q   = 1'b1;
    end else begin
      res.rem = trial[PERIOD_W-1:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/pattern_dither_mask_fill_top.sv =====
// Screen-door dither fill behind a shape mask: pixel stream in, write request out.
//
// Input stream (s_*): one request per pixel, tdata = {mask_value, pixel_y, pixel_x}.
// Output stream (m_*): one result per pixel, tdata = {pixel_out, write_enable}.
// Configuration: APB-style port, registers at 0x00 dither_mode, 0x04 period,
// 0x08 fill_color, 0x0C x_offset, 0x10 y_offset; pready is tied high.
// Stages: one for the offset add, one per four bits of restoring division
// by the period, one for the pattern test.
// Throughput: one pixel per clock while m_tready is high; every stage is a
// register with its own valid bit, and the division pipeline handles a new
// pixel each cycle unless stalled.
// Stalls: when m_tready is low, ready backs up stage by stage; empty stages
// keep filling, so nothing is lost or repeated.
// Reset: all stages empty, registers return to mode 0, period 1, color 0,
// offsets 0. Write configuration only with the pipeline drained.
// Depends on pdmf_pkg, pdmf_regs, pdmf_div_stage and pdmf_pattern.
module pattern_dither_mask_fill_top #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // Pixel request stream
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // tdata: pixel_x, pixel_y, mask_value (low to high), zero padded to bytes
  input  logic [((2*COORD_WIDTH+pdmf_pkg::MASK_W+7)/8)*8-1:0] s_tdata,
  // Result stream
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // tdata: write_enable, pixel_out (low to high), zero padded to bytes
  output logic [pdmf_pkg::OUT_TDATA_W-1:0]          m_tdata,
  // Configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [pdmf_pkg::CFG_ADDR_W-1:0]           paddr,
  input  logic [pdmf_pkg::CFG_DATA_W-1:0]           pwdata,
  output logic [pdmf_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                      pready
);
  import pdmf_pkg::*;

  localparam int SUM_W          = COORD_WIDTH + 1;
  localparam int NUM_DIV_STAGES = (SUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int DVD_W          = NUM_DIV_STAGES * DIV_BITS_PER_STAGE;

  cfg_t                  cfg;
  logic [PERIOD_W-1:0]   divisor;

  logic [COORD_WIDTH-1:0] pixel_x;
  logic [COORD_WIDTH-1:0] pixel_y;
  logic [MASK_W-1:0]      mask_value;
  logic [COORD_WIDTH-1:0] off_x;
  logic [COORD_WIDTH-1:0] off_y;
  logic [SUM_W-1:0]       sum_x;
  logic [SUM_W-1:0]       sum_y;

  // Pipeline links: index 0 is the add stage, the last one feeds the pattern stage
  logic             pl_valid [NUM_DIV_STAGES+1];
  logic             pl_ready [NUM_DIV_STAGES+1];
  div_state_t       pl_st    [NUM_DIV_STAGES+1];
  logic [DVD_W-1:0] pl_dvd_x [NUM_DIV_STAGES+1];
  logic [DVD_W-1:0] pl_dvd_y [NUM_DIV_STAGES+1];

  // Configuration registers
  pdmf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Zero period behaves as period one
  assign divisor = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;

  // Unpack request and add offsets (low COORD_WIDTH bits of each)
  assign pixel_x    = s_tdata[COORD_WIDTH-1:0];
  assign pixel_y    = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign mask_value = s_tdata[2*COORD_WIDTH+MASK_W-1:2*COORD_WIDTH];
  assign off_x      = COORD_WIDTH'(cfg.x_offset);
  assign off_y      = COORD_WIDTH'(cfg.y_offset);
  assign sum_x      = SUM_W'(pixel_x) + SUM_W'(off_x);
  assign sum_y      = SUM_W'(pixel_y) + SUM_W'(off_y);

  // Add stage
  assign s_tready = !pl_valid[0] || pl_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pl_valid[0] <= 1'b0;
    end else if (s_tready) begin
      pl_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      pl_dvd_x[0]      <= DVD_W'(sum_x);
      pl_dvd_y[0]      <= DVD_W'(sum_y);
      pl_st[0].rem_x   <= '0;
      pl_st[0].rem_y   <= '0;
      pl_st[0].qbit_x  <= 1'b0;
      pl_st[0].qbit_y  <= 1'b0;
      pl_st[0].mask_nz <= (mask_value != '0);
    end
  end

  // Division stages
  for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
    pdmf_div_stage #(
      .DVD_W (DVD_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .divisor   (divisor),
      .in_valid  (pl_valid[g]),
      .in_ready  (pl_ready[g]),
      .in_st     (pl_st[g]),
      .in_dvd_x  (pl_dvd_x[g]),
      .in_dvd_y  (pl_dvd_y[g]),
      .out_valid (pl_valid[g+1]),
      .out_ready (pl_ready[g+1]),
      .out_st    (pl_st[g+1]),
      .out_dvd_x (pl_dvd_x[g+1]),
      .out_dvd_y (pl_dvd_y[g+1])
    );
  end

  // Pattern test and output register
  pdmf_pattern u_pattern (
    .clk         (clk),
    .rst         (rst),
    .divisor     (divisor),
    .dither_mode (cfg.dither_mode),
    .fill_color  (cfg.fill_color),
    .in_valid    (pl_valid[NUM_DIV_STAGES]),
    .in_ready    (pl_ready[NUM_DIV_STAGES]),
    .in_st       (pl_st[NUM_DIV_STAGES]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== hw/rtl/pdmf_regs.sv =====
// APB-style configuration register file for the pattern dither mask fill block.
// Depends on pdmf_pkg for register indexes and the cfg_t layout.
module pdmf_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdmf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pdmf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pdmf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output pdmf_pkg::cfg_t                  cfg
);
  import pdmf_pkg::*;

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = regs;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dither_mode <= '0;
      regs.period      <= PERIOD_W'(1);
      regs.fill_color  <= '0;
      regs.x_offset    <= '0;
      regs.y_offset    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DITHER_MODE: regs.dither_mode <= pwdata[MODE_W-1:0];
        REG_PERIOD:      regs.period      <= pwdata[PERIOD_W-1:0];
        REG_FILL_COLOR:  regs.fill_color  <= pwdata[COLOR_W-1:0];
        REG_X_OFFSET:    regs.x_offset    <= pwdata[OFFSET_W-1:0];
        REG_Y_OFFSET:    regs.y_offset    <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_DITHER_MODE: prdata = CFG_DATA_W'(regs.dither_mode);
      REG_PERIOD:      prdata = CFG_DATA_W'(regs.period);
      REG_FILL_COLOR:  prdata = CFG_DATA_W'(regs.fill_color);
      REG_X_OFFSET:    prdata = CFG_DATA_W'(regs.x_offset);
      REG_Y_OFFSET:    prdata = CFG_DATA_W'(regs.y_offset);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/pdmf_div_stage.sv =====
// One pipeline stage of restoring division of both coordinates by the period.
// Depends on pdmf_pkg for div_state_t and div_step().
module pdmf_div_stage #(
  parameter int DVD_W = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pdmf_pkg::PERIOD_W-1:0] divisor,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pdmf_pkg::div_state_t          in_st,
  input  logic [DVD_W-1:0]              in_dvd_x,
  input  logic [DVD_W-1:0]              in_dvd_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pdmf_pkg::div_state_t          out_st,
  output logic [DVD_W-1:0]              out_dvd_x,
  output logic [DVD_W-1:0]              out_dvd_y
);
  import pdmf_pkg::*;

  logic             valid;
  div_state_t       st;
  logic [DVD_W-1:0] dvd_x;
  logic [DVD_W-1:0] dvd_y;

  div_state_t       st_next;
  logic [DVD_W-1:0] dvd_x_next;
  logic [DVD_W-1:0] dvd_y_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_st    = st;
  assign out_dvd_x = dvd_x;
  assign out_dvd_y = dvd_y;

  // DIV_BITS_PER_STAGE division steps, dividend consumed MSB first
  always_comb begin
    div_step_t sx;
    div_step_t sy;
    st_next    = in_st;
    dvd_x_next = in_dvd_x;
    dvd_y_next = in_dvd_y;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      sx = div_step(st_next.rem_x, dvd_x_next[DVD_W-1], divisor);
      sy = div_step(st_next.rem_y, dvd_y_next[DVD_W-1], divisor);
      st_next.rem_x  = sx.rem;
      st_next.qbit_x = sx.q;
      st_next.rem_y  = sy.rem;
      st_next.qbit_y = sy.q;
      dvd_x_next = {dvd_x_next[DVD_W-2:0], 1'b0};
      dvd_y_next = {dvd_y_next[DVD_W-2:0], 1'b0};
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st    <= st_next;
      dvd_x <= dvd_x_next;
      dvd_y <= dvd_y_next;
    end
  end

endmodule

// ===== hw/rtl/pdmf_pattern.sv =====
// Final stage: pattern test on quotient bits and remainders, plus the output register.
// Depends on pdmf_pkg for pattern codes, div_state_t and widths.
module pdmf_pattern (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pdmf_pkg::PERIOD_W-1:0]    divisor,
  input  logic [pdmf_pkg::MODE_W-1:0]      dither_mode,
  input  logic [pdmf_pkg::COLOR_W-1:0]     fill_color,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pdmf_pkg::div_state_t             in_st,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pdmf_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import pdmf_pkg::*;

  logic               valid;
  logic               write_enable;
  logic [COLOR_W-1:0] pixel_out;

  logic               hit;
  logic               holds;
  logic [CODE_W-1:0]  code;
  logic               mx0;
  logic               my0;
  logic               mx_eq_my;

  assign code     = dither_mode[MODE_W-1:1];
  assign mx0      = (in_st.rem_x == '0);
  assign my0      = (in_st.rem_y == '0);
  assign mx_eq_my = (in_st.rem_x == in_st.rem_y);

  // Pattern test
  always_comb begin
    unique case (pattern_t'(code))
      PAT_CHECKER:    holds = in_st.qbit_x ^ in_st.qbit_y;
      PAT_CRISSCROSS: holds = mx_eq_my || ((divisor - in_st.rem_x) == in_st.rem_y);
      PAT_DIAG_DR:    holds = mx_eq_my;
      PAT_DIAG_UR:    holds = ((divisor - PERIOD_W'(1) - in_st.rem_x) == in_st.rem_y);
      PAT_ROWS:       holds = my0;
      PAT_COLUMNS:    holds = mx0;
      PAT_DOTS:       holds = mx0 && my0;
      PAT_GRID:       holds = mx0 || my0;
      default:        holds = 1'b1;
    endcase
  end

  // Codes eight and up ignore the invert bit
  assign hit = code[CODE_W-1] ? 1'b1 : (holds ^ dither_mode[0]);

  assign in_ready = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = OUT_TDATA_W'({pixel_out, write_enable});

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      write_enable <= in_st.mask_nz && hit;
      pixel_out    <= fill_color;
    end
  end

endmodule
